// ----- hdl/sle_pkg.sv -----
// shared constants, codes and types for the sorted list engine
package sle_pkg;

   // store depth and derived widths
   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int TOTAL_W  = 5;

   // stream payload widths, padded to whole bytes
   localparam int REQ_W = 40;
   localparam int RSP_W = 40;

   // action codes
   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_POP    = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   // status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;    // capture the accepted item
      logic exec;    // apply the captured item and register its result
   } cmd_type;

endpackage

// ----- hdl/sle_datapath.sv -----
// sorted register row with per-entry comparators, operand and result registers
module sle_datapath
   import sle_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [REQ_W-1:0]   req_data,
   output logic [RSP_W-1:0]   rsp_data
);

   logic [1:0]               action_ff;
   logic signed [KEY_W-1:0]  key_ff;
   logic signed [KEY_W-1:0]  vals_ff [CAPACITY];
   logic signed [KEY_W-1:0]  vals_in [CAPACITY];
   logic signed [KEY_W-1:0]  ins_val [CAPACITY];
   logic signed [KEY_W-1:0]  rem_val [CAPACITY];
   logic signed [KEY_W-1:0]  pop_val [CAPACITY];
   logic [CAPACITY-1:0]      lt;
   logic [CAPACITY-1:0]      eq;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     found;
   logic                     full;
   logic                     empty;
   status_type               status;
   logic [RSP_W-1:0]         rsp_ff;
   logic signed [KEY_W-1:0]  smallest;

   // per-entry compare and shift candidates
   for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
      assign lt[i] = (CNT_W'(i) < count_ff) && (vals_ff[i] < key_ff);
      assign eq[i] = (CNT_W'(i) < count_ff) && (vals_ff[i] == key_ff);

      if (i == 0) begin : g_first
         assign ins_val[i] = lt[i] ? vals_ff[i] : key_ff;
      end else begin : g_rest
         assign ins_val[i] = lt[i] ? vals_ff[i] : (lt[i-1] ? key_ff : vals_ff[i-1]);
      end

      if (i == CAPACITY - 1) begin : g_last
         assign rem_val[i] = vals_ff[i];
         assign pop_val[i] = vals_ff[i];
      end else begin : g_inner
         assign rem_val[i] = lt[i] ? vals_ff[i] : vals_ff[i+1];
         assign pop_val[i] = vals_ff[i+1];
      end
   end

   assign found = |eq;
   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   // action decode and next store contents
   always_comb begin
      vals_in  = vals_ff;
      count_in = count_ff;
      status   = ST_OK;
      case (action_type'(action_ff))
         ACT_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               vals_in  = ins_val;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ACT_REMOVE: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (!found) begin
               status = ST_NOT_FOUND;
            end else begin
               vals_in  = rem_val;
               count_in = count_ff - CNT_W'(1);
            end
         end
         ACT_POP: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               vals_in  = pop_val;
               count_in = count_ff - CNT_W'(1);
            end
         end
         ACT_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign smallest = (count_in == '0) ? '0 : vals_in[0];

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   // operands, store row and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_data[1:0];
         key_ff    <= req_data[KEY_W+1:2];
      end
      if (cmd.exec) begin
         vals_ff <= vals_in;
         rsp_ff  <= {smallest, TOTAL_W'(count_in), (count_in == '0), status};
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- hdl/sle_ctrl.sv -----
// controller: accept, execute and result handshake sequencing
module sle_ctrl
   import sle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   // take an item while idle, once the result slot is free or draining this cycle
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign cmd.load = accept;
   assign cmd.exec = (state_ff == S_EXEC);

   // state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (rsp_valid_ff && rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (accept) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- hdl/sorted_list_engine.sv -----
// top level of the sorted list engine
// Keeps up to CAPACITY signed 32-bit values in nondecreasing order in a row of
// registers, each with its own comparator against the item's key. Each item
// (insert, remove key, remove smallest, clear) is first captured, then in the
// execute state all comparators and the one-place shift of the whole row
// update the store and load the result register. A new item is taken while the
// previous result waits, as long as that result is taken by then, but not before
// the previous item has executed. Every item gives one result.
module sorted_list_engine
   import sle_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // [1:0] action, [33:2] key, [39:34] zero
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [1:0] status, [2] store_empty, [7:3] entry_total, [39:8] smallest_value
   output logic [RSP_W-1:0] rsp_tdata
);

   cmd_type cmd;

   // handshake and sequencing
   sle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // store and result
   sle_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_tdata),
      .rsp_data (rsp_tdata)
   );

endmodule

// ----- test/tb_top.sv -----
// testbench for the sorted list engine: random and directed items against a queue-based predictor
`timescale 1ns / 100ps

module tb_top;
   import sle_pkg::*;

   // expected result of one item
   typedef struct {
      status_type  status;
      logic        store_empty;
      logic [4:0]  entry_total;
      logic [31:0] smallest;
   } rsp_fields_type;

   // predicts the sorted store and checks results in order
   class queue_tracker;
      int             held_keys[$];
      rsp_fields_type pending_rsp[$];
      int             fail_count;

      function new();
         fail_count = 0;
      endfunction

      // apply an accepted item to the predicted store and queue its result
      function void note_request(action_type act, logic [31:0] key_bits);
         int             key;
         int             pos;
         rsp_fields_type exp;
         key = key_bits;
         exp.status = ST_OK;
         case (act)
            ACT_INSERT: begin
               if (held_keys.size() >= CAPACITY) begin
                  exp.status = ST_FULL;
               end else begin
                  pos = 0;
                  while (pos < held_keys.size() && held_keys[pos] < key) pos++;
                  held_keys.insert(pos, key);
               end
            end
            ACT_REMOVE: begin
               if (held_keys.size() == 0) begin
                  exp.status = ST_EMPTY;
               end else begin
                  pos = 0;
                  while (pos < held_keys.size() && held_keys[pos] != key) pos++;
                  if (pos >= held_keys.size()) exp.status = ST_NOT_FOUND;
                  else held_keys.delete(pos);
               end
            end
            ACT_POP: begin
               if (held_keys.size() == 0) exp.status = ST_EMPTY;
               else held_keys.delete(0);
            end
            default: begin
               held_keys.delete();
            end
         endcase
         exp.store_empty = (held_keys.size() == 0);
         exp.entry_total = 5'(held_keys.size());
         exp.smallest    = (held_keys.size() == 0) ? 32'd0 : held_keys[0];
         pending_rsp.push_back(exp);
      endfunction

      // compare one accepted result with the oldest expectation
      function void check_response(logic [RSP_W-1:0] data);
         rsp_fields_type exp;
         if (pending_rsp.size() == 0) begin
            $error("result 0x%h arrived with no item pending", data);
            fail_count++;
            return;
         end
         exp = pending_rsp.pop_front();
         if (data[1:0] !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, data[1:0]);
            fail_count++;
         end
         if (data[2] !== exp.store_empty) begin
            $error("store_empty: expected %0d, actual %0d", exp.store_empty, data[2]);
            fail_count++;
         end
         if (data[7:3] !== exp.entry_total) begin
            $error("entry_total: expected %0d, actual %0d", exp.entry_total, data[7:3]);
            fail_count++;
         end
         if (data[39:8] !== exp.smallest) begin
            $error("smallest_value: expected %0d, actual %0d",
                   $signed(exp.smallest), $signed(data[39:8]));
            fail_count++;
         end
      endfunction

      function int pending();
         return pending_rsp.size();
      endfunction

      // a key currently held, or a random one when the store is empty
      function logic [31:0] pick_held();
         if (held_keys.size() == 0) return $urandom;
         return held_keys[$urandom_range(held_keys.size() - 1)];
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 175;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   queue_tracker tracker = new();
   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   bit  hold_go   = 1'b0;
   bit  hold_done = 1'b0;
   int  stall_left = 0;
   int  cycle_count = 0;

   sorted_list_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL sorted_list_engine");
         $finish;
      end
   end

   // sample both handshakes at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.note_request(action_type'(req_tdata[1:0]), req_tdata[33:2]);
         if (rsp_tvalid && rsp_tready)
            tracker.check_response(rsp_tdata);
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         stall_left = HOLD_CYCLES;
         hold_done  = 1'b1;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // offer one item and wait until it is taken
   task automatic offer_item(action_type act, logic [31:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {{(REQ_W - 34){1'b0}}, key, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // key mix: small signed values, duplicates, full range, extremes
   function automatic logic [31:0] choose_key();
      int r;
      r = $urandom_range(9);
      if (r < 4) return $urandom_range(16) - 8;
      if (r < 6) return tracker.pick_held();
      if (r < 9) return $urandom;
      case ($urandom_range(3))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   // one random item; mode 0 fills, 1 drains, 2 mixes
   task automatic random_item(int mode);
      int          roll;
      int          ins_lim;
      int          rem_lim;
      int          pop_lim;
      action_type  act;
      logic [31:0] key;
      roll = $urandom_range(99);
      case (mode)
         0: begin ins_lim = 75; rem_lim = 90; pop_lim = 98; end
         1: begin ins_lim = 25; rem_lim = 60; pop_lim = 96; end
         default: begin ins_lim = 45; rem_lim = 72; pop_lim = 96; end
      endcase
      if (roll < ins_lim) begin
         act = ACT_INSERT;
         key = choose_key();
      end else if (roll < rem_lim) begin
         act = ACT_REMOVE;
         key = ($urandom_range(9) < 7) ? tracker.pick_held() : choose_key();
      end else if (roll < pop_lim) begin
         act = ACT_POP;
         key = $urandom;
      end else begin
         act = ACT_CLEAR;
         key = $urandom;
      end
      offer_item(act, key);
   endtask

   int send_idle_set[4]  = '{0, 66, 0, 38};
   int recv_stall_set[4] = '{0, 0, 66, 38};

   initial begin
      int sent;
      int run_len;
      int mode;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty store cases, extremes, duplicates, misses, full store
      offer_item(ACT_POP, 32'h0);
      offer_item(ACT_REMOVE, 32'h5);
      offer_item(ACT_CLEAR, 32'hffff_ffff);
      offer_item(ACT_INSERT, 32'h7fff_ffff);
      offer_item(ACT_INSERT, 32'h8000_0000);
      offer_item(ACT_INSERT, 32'hffff_ffff);
      offer_item(ACT_INSERT, 32'h0);
      offer_item(ACT_INSERT, 32'h5);
      offer_item(ACT_INSERT, 32'h5);
      offer_item(ACT_REMOVE, 32'h5);
      offer_item(ACT_REMOVE, 32'd42);
      offer_item(ACT_POP, 32'h7fff_ffff);
      for (int i = 0; i < 12; i++) offer_item(ACT_INSERT, choose_key());
      offer_item(ACT_INSERT, 32'h1234_5678);
      offer_item(ACT_CLEAR, 32'h0);

      // random phases with different idling, runs biased to fill or drain
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = send_idle_set[ph];
         recv_stall_pct = recv_stall_set[ph];
         if (ph == 0) hold_go = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            run_len = $urandom_range(8, 40);
            mode    = $urandom_range(2);
            for (int i = 0; i < run_len && sent < PHASE_ITEMS; i++) begin
               random_item(mode);
               sent++;
            end
         end
      end
      req_tvalid = 1'b0;

      // drain and let the block settle
      while (tracker.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.fail_count == 0) begin
         $display("PASS sorted_list_engine");
      end else begin
         $display("FAIL sorted_list_engine");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/sle_pkg.sv
hdl/sle_datapath.sv
hdl/sle_ctrl.sv
hdl/sorted_list_engine.sv
test/tb_top.sv
